// File: hw/rtl/assert_macros.svh
// assertion shorthands for the sample byte offset resolver
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds, consequent holds in the same cycle
`define CHK_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds, consequent holds in the next cycle
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/sbor_pkg.sv
// shared types, codes and widths for the sample byte offset resolver
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package sbor_pkg;

  localparam int unsigned CHUNK_DEPTH_DEF = 4096;
  localparam int unsigned RUN_DEPTH_DEF   = 1024;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned IDX_W  = 12;
  localparam int unsigned OFS_W  = 64;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned CIU_W  = 13;
  localparam int unsigned RIU_W  = 11;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned ALU_W  = 34;
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_CHUNKS  = 2'd0;
  localparam logic [1:0] REG_RUNS    = 2'd1;
  localparam logic [1:0] REG_SAMPLES = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_CHUNK = 2'd0,
    OP_LOAD_RUN   = 2'd1,
    OP_PLACE      = 2'd2,
    OP_RESTART    = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_BEYOND   = 2'd1,
    ST_NO_CHUNK = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    W_IDLE,
    W_CHECK,
    W_RUN_RD,
    W_RUN_CNT,
    W_RUN_TEST,
    W_RUN_SUB,
    W_CHUNK,
    W_TABLE,
    W_CRD,
    W_POS,
    W_DONE
  } walk_state_t;

  typedef struct packed {
    logic [CIU_W-1:0] chunks_in_use;
    logic [RIU_W-1:0] runs_in_use;
    logic [CNT_W-1:0] samples_in_use;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] first_chunk;
    logic [CNT_W-1:0] samples_per_chunk;
  } run_word_t;

  // shared adder: a + (inv_b ? ~b : b) + cin
  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             inv_b;
    logic             cin;
  } alu_req_t;

  typedef struct packed {
    logic [OFS_W-1:0] position;
    logic [CNT_W-1:0] number;
    status_t          status;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/sbor_alu.sv
// shared add / subtract / compare unit of the walk sequencer
// depends on sbor_pkg for the request type and width
`timescale 1ns / 1ps
`default_nettype none

module sbor_alu
  import sbor_pkg::*;
(
  input  alu_req_t         req,
  output logic [ALU_W-1:0] sum
);

  logic [ALU_W-1:0] b_op;

  assign b_op = req.inv_b ? ~req.b : req.b;
  assign sum  = req.a + b_op + ALU_W'(req.cin);

endmodule

`default_nettype wire

// File: hw/rtl/sbor_chunk_mem.sv
// chunk offset store: one write port, one registered read port
// depends on sbor_pkg for the offset width
`timescale 1ns / 1ps
`default_nettype none

module sbor_chunk_mem
  import sbor_pkg::*;
#(
  parameter  int unsigned DEPTH = CHUNK_DEPTH_DEF,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [OFS_W-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [OFS_W-1:0] rdata
);

  logic [OFS_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/sbor_run_mem.sv
// sample-to-chunk run store: one write port, two registered read ports
// depends on sbor_pkg for the run word type
`timescale 1ns / 1ps
`default_nettype none

module sbor_run_mem
  import sbor_pkg::*;
#(
  parameter  int unsigned DEPTH = RUN_DEPTH_DEF,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  run_word_t     wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output run_word_t     rdata_a,
  output run_word_t     rdata_b
);

  run_word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// File: hw/rtl/sbor_cfg_regs.sv
// apb-style configuration registers: chunk, run and sample counts
// depends on sbor_pkg for the register struct and indexes
`timescale 1ns / 1ps
`default_nettype none

module sbor_cfg_regs
  import sbor_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CHUNKS:  cfg_r.chunks_in_use  <= pwdata[CIU_W-1:0];
        REG_RUNS:    cfg_r.runs_in_use    <= pwdata[RIU_W-1:0];
        REG_SAMPLES: cfg_r.samples_in_use <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CHUNKS:  prdata = APB_DW'(cfg_r.chunks_in_use);
      REG_RUNS:    prdata = APB_DW'(cfg_r.runs_in_use);
      REG_SAMPLES: prdata = APB_DW'(cfg_r.samples_in_use);
      default:     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/sbor_walker.sv
// walk sequencer: steps through the runs and chunks with one shared adder
// depends on sbor_pkg and sbor_alu; reads the run and chunk stores
`timescale 1ns / 1ps
`default_nettype none

module sbor_walker
  import sbor_pkg::*;
#(
  parameter  int unsigned CHUNK_DEPTH = CHUNK_DEPTH_DEF,
  parameter  int unsigned RUN_DEPTH   = RUN_DEPTH_DEF,
  localparam int unsigned CA_W = (CHUNK_DEPTH > 1) ? $clog2(CHUNK_DEPTH) : 1,
  localparam int unsigned RA_W = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [OP_W-1:0]  in_operation,
  input  logic [CNT_W-1:0] in_sample_size,
  input  cfg_t             cfg,
  output logic [RA_W-1:0]  run_addr_a,
  output logic [RA_W-1:0]  run_addr_b,
  input  run_word_t        run_cur,
  input  run_word_t        run_next,
  output logic [CA_W-1:0]  chunk_addr,
  input  logic [OFS_W-1:0] chunk_data,
  output logic             res_valid,
  input  logic             res_ready,
  output result_t          res
);

  localparam int unsigned RI_W  = $clog2(RUN_DEPTH + 1);
  localparam int unsigned RC_W  = (RI_W > RIU_W) ? RI_W : RIU_W;
  localparam int unsigned RC1_W = RC_W + 1;
  localparam int unsigned CC_W  =
    ($clog2(CHUNK_DEPTH + 1) > CIU_W) ? $clog2(CHUNK_DEPTH + 1) : CIU_W;

  walk_state_t      state_r, state_nxt;
  logic [RI_W-1:0]  cur_run_r;
  logic [CNT_W-1:0] chunk_in_run_r;
  logic [CNT_W-1:0] sample_in_chunk_r;
  logic [OFS_W-1:0] running_offset_r;
  logic [CNT_W-1:0] samples_placed_r;
  logic [CIU_W-1:0] chunks_remaining_r;
  logic [CNT_W-1:0] run_chunks_r;
  logic [CNT_W-1:0] size_r;
  logic [CNT_W:0]   chunk_no_r;
  logic             in_table_r;
  logic [CA_W-1:0]  chunk_addr_r;
  result_t          res_r;

  alu_req_t         alu_req;
  logic [ALU_W-1:0] alu_sum;
  logic             alu_neg;

  logic [RC_W-1:0]  runs_x, runs_act, cur_x;
  logic [RC1_W-1:0] cur_inc;
  logic             cur_beyond, not_last, walk_start, run_found, table_hit;
  logic [CC_W-1:0]  chunks_x, chunks_act;
  logic [CNT_W:0]   sic_inc, chunk_idx;
  logic [OFS_W-1:0] base_ofs;
  op_t              op;

  sbor_alu u_alu (
    .req (alu_req),
    .sum (alu_sum)
  );

  assign alu_neg = alu_sum[ALU_W-1];
  assign op      = op_t'(in_operation);

  // clamp the counts to the store depths
  assign runs_x     = RC_W'(cfg.runs_in_use);
  assign runs_act   = (runs_x > RC_W'(RUN_DEPTH)) ? RC_W'(RUN_DEPTH) : runs_x;
  assign chunks_x   = CC_W'(cfg.chunks_in_use);
  assign chunks_act = (chunks_x > CC_W'(CHUNK_DEPTH)) ? CC_W'(CHUNK_DEPTH) : chunks_x;

  assign cur_x      = RC_W'(cur_run_r);
  assign cur_inc    = {1'b0, cur_x} + RC1_W'(1);
  assign cur_beyond = cur_x >= runs_act;
  assign not_last   = cur_inc < {1'b0, runs_act};

  assign run_addr_a = (cur_x < RC_W'(RUN_DEPTH)) ? cur_run_r[RA_W-1:0] : '0;
  assign run_addr_b = (cur_inc < RC1_W'(RUN_DEPTH)) ? cur_inc[RA_W-1:0] : '0;
  assign chunk_addr = chunk_addr_r;

  assign walk_start = (samples_placed_r == '0) && (cur_run_r == '0) &&
                      (chunk_in_run_r == '0);
  assign run_found  = alu_neg && (run_cur.samples_per_chunk != '0);
  assign table_hit  = alu_neg && (chunk_no_r != '0);
  assign chunk_idx  = chunk_no_r - (CNT_W + 1)'(1);
  assign sic_inc    = {1'b0, sample_in_chunk_r} + (CNT_W + 1)'(1);
  assign base_ofs   = (sample_in_chunk_r == '0) ?
                      (in_table_r ? chunk_data : '0) : running_offset_r;

  assign res = res_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      W_IDLE: begin
        if (in_valid && op == OP_PLACE) state_nxt = W_CHECK;
      end
      W_CHECK:    state_nxt = alu_neg ? W_RUN_RD : W_DONE;
      W_RUN_RD:   state_nxt = cur_beyond ? W_DONE : W_RUN_CNT;
      W_RUN_CNT:  state_nxt = W_RUN_TEST;
      W_RUN_TEST: begin
        priority if (run_found) state_nxt = W_CHUNK;
        else if (not_last)      state_nxt = W_RUN_SUB;
        else                    state_nxt = W_RUN_RD;
      end
      W_RUN_SUB:  state_nxt = W_RUN_RD;
      W_CHUNK:    state_nxt = W_TABLE;
      W_TABLE:    state_nxt = W_CRD;
      W_CRD:      state_nxt = W_POS;
      W_POS:      state_nxt = W_DONE;
      W_DONE: begin
        if (res_ready) state_nxt = W_IDLE;
      end
      default:    state_nxt = W_IDLE;
    endcase
  end

  // operand selection for the shared unit, handshake outputs
  always_comb begin
    alu_req   = '0;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    unique case (state_r)
      W_IDLE: in_ready = 1'b1;
      W_CHECK: begin
        alu_req.a     = ALU_W'(samples_placed_r);
        alu_req.b     = ALU_W'(cfg.samples_in_use);
        alu_req.inv_b = 1'b1;
        alu_req.cin   = 1'b1;
      end
      W_RUN_CNT: begin
        alu_req.a     = ALU_W'(run_next.first_chunk);
        alu_req.b     = ALU_W'(run_cur.first_chunk);
        alu_req.inv_b = 1'b1;
        alu_req.cin   = 1'b1;
      end
      W_RUN_TEST: begin
        alu_req.a     = ALU_W'(chunk_in_run_r);
        alu_req.b     = ALU_W'(run_chunks_r);
        alu_req.inv_b = 1'b1;
        alu_req.cin   = 1'b1;
      end
      W_RUN_SUB: begin
        alu_req.a     = ALU_W'(chunks_remaining_r);
        alu_req.b     = ALU_W'(run_chunks_r);
        alu_req.inv_b = 1'b1;
        alu_req.cin   = 1'b1;
      end
      W_CHUNK: begin
        alu_req.a = ALU_W'(run_cur.first_chunk);
        alu_req.b = ALU_W'(chunk_in_run_r);
      end
      // chunk - active - 1 goes negative when the chunk lies in the table
      W_TABLE: begin
        alu_req.a     = ALU_W'(chunk_no_r);
        alu_req.b     = ALU_W'(chunks_act);
        alu_req.inv_b = 1'b1;
      end
      // sample_in_chunk + 1 - samples_per_chunk, not negative: chunk full
      W_POS: begin
        alu_req.a     = ALU_W'(sic_inc);
        alu_req.b     = ALU_W'(run_cur.samples_per_chunk);
        alu_req.inv_b = 1'b1;
        alu_req.cin   = 1'b1;
      end
      W_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  // walk state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= W_IDLE;
      cur_run_r          <= '0;
      chunk_in_run_r     <= '0;
      sample_in_chunk_r  <= '0;
      running_offset_r   <= '0;
      samples_placed_r   <= '0;
      chunks_remaining_r <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        W_IDLE: begin
          if (in_valid && op == OP_RESTART) begin
            cur_run_r          <= '0;
            chunk_in_run_r     <= '0;
            sample_in_chunk_r  <= '0;
            running_offset_r   <= '0;
            samples_placed_r   <= '0;
            chunks_remaining_r <= '0;
          end
        end
        W_CHECK: begin
          if (walk_start) chunks_remaining_r <= cfg.chunks_in_use;
        end
        W_RUN_TEST: begin
          // last run exhausted: step past it without touching the remainder
          if (!run_found && !not_last) begin
            cur_run_r         <= cur_run_r + RI_W'(1);
            chunk_in_run_r    <= '0;
            sample_in_chunk_r <= '0;
          end
        end
        W_RUN_SUB: begin
          chunks_remaining_r <= alu_neg ? '0 : alu_sum[CIU_W-1:0];
          cur_run_r          <= cur_run_r + RI_W'(1);
          chunk_in_run_r     <= '0;
          sample_in_chunk_r  <= '0;
        end
        W_POS: begin
          running_offset_r <= base_ofs + OFS_W'(size_r);
          samples_placed_r <= samples_placed_r + CNT_W'(1);
          if (!alu_neg) begin
            sample_in_chunk_r <= '0;
            chunk_in_run_r    <= chunk_in_run_r + CNT_W'(1);
          end else begin
            sample_in_chunk_r <= sic_inc[CNT_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // working values and the result
  always_ff @(posedge clk) begin
    unique case (state_r)
      W_IDLE: begin
        if (in_valid && op == OP_PLACE) size_r <= in_sample_size;
      end
      W_CHECK: begin
        res_r.position <= '0;
        res_r.number   <= samples_placed_r;
        res_r.status   <= ST_BEYOND;
      end
      W_RUN_CNT: begin
        if (not_last) begin
          run_chunks_r <= alu_neg ? '0 : alu_sum[CNT_W-1:0];
        end else begin
          run_chunks_r <= CNT_W'(chunks_remaining_r);
        end
      end
      W_CHUNK: chunk_no_r <= alu_sum[CNT_W:0];
      W_TABLE: begin
        in_table_r   <= table_hit;
        chunk_addr_r <= table_hit ? chunk_idx[CA_W-1:0] : '0;
      end
      W_POS: begin
        res_r.position <= in_table_r ? base_ofs : '0;
        res_r.status   <= in_table_r ? ST_OK : ST_NO_CHUNK;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/sample_byte_offset_resolver.sv
// Sample byte offset resolver. Load transactions (operation 0 and 1) write one
// chunk offset or one sample-to-chunk run entry; restart (operation 3) clears
// the walk; neither gives a result. A place transaction (operation 2) returns
// the file position and number of the next sample; the block takes no new
// transaction until the walk is finished and its result has moved to the
// output register. The walk sequencer relies on the single shared 34-bit
// add/compare unit and on the registered reads of the run and chunk stores.
// Status 1 flags samples past the configured count or past the last run,
// status 2 a chunk number outside the loaded table. The stores need no
// clearing pass: entries must be loaded before the walk reaches them. The
// result sits in an output register, so loads are taken while a result
// waits. Registers at byte addresses 0, 4 and 8: chunk count, run count,
// sample count.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sample_byte_offset_resolver
  import sbor_pkg::*;
#(
  parameter int unsigned CHUNK_DEPTH = CHUNK_DEPTH_DEF,
  parameter int unsigned RUN_DEPTH   = RUN_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [IDX_W-1:0]  in_entry_index,
  input  logic [OFS_W-1:0]  in_chunk_offset,
  input  logic [CNT_W-1:0]  in_first_chunk,
  input  logic [CNT_W-1:0]  in_samples_per_chunk,
  input  logic [CNT_W-1:0]  in_sample_size,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [OFS_W-1:0]  out_sample_position,
  output logic [CNT_W-1:0]  out_sample_number,
  output logic [STAT_W-1:0] out_status
);

  localparam int unsigned CA_W = (CHUNK_DEPTH > 1) ? $clog2(CHUNK_DEPTH) : 1;
  localparam int unsigned RA_W = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;

  cfg_t             cfg;
  logic             in_accept;
  op_t              op;
  logic             chunk_we, run_we;
  run_word_t        run_wdata, run_cur, run_next;
  logic [RA_W-1:0]  run_addr_a, run_addr_b;
  logic [CA_W-1:0]  chunk_addr;
  logic [OFS_W-1:0] chunk_data;
  logic             res_valid, res_ready;
  result_t          res;

  logic             out_valid_r;
  result_t          out_r;

  sbor_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_accept = in_valid && in_ready;
  assign op        = op_t'(in_operation);

  // loads beyond the store depth are dropped
  assign chunk_we  = in_accept && (op == OP_LOAD_CHUNK) &&
                     (32'(in_entry_index) < CHUNK_DEPTH);
  assign run_we    = in_accept && (op == OP_LOAD_RUN) &&
                     (32'(in_entry_index) < RUN_DEPTH);
  assign run_wdata = '{first_chunk: in_first_chunk,
                       samples_per_chunk: in_samples_per_chunk};

  sbor_chunk_mem #(
    .DEPTH (CHUNK_DEPTH)
  ) u_chunk_mem (
    .clk   (clk),
    .we    (chunk_we),
    .waddr (CA_W'(in_entry_index)),
    .wdata (in_chunk_offset),
    .raddr (chunk_addr),
    .rdata (chunk_data)
  );

  sbor_run_mem #(
    .DEPTH (RUN_DEPTH)
  ) u_run_mem (
    .clk     (clk),
    .we      (run_we),
    .waddr   (RA_W'(in_entry_index)),
    .wdata   (run_wdata),
    .raddr_a (run_addr_a),
    .raddr_b (run_addr_b),
    .rdata_a (run_cur),
    .rdata_b (run_next)
  );

  sbor_walker #(
    .CHUNK_DEPTH (CHUNK_DEPTH),
    .RUN_DEPTH   (RUN_DEPTH)
  ) u_walker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_sample_size (in_sample_size),
    .cfg            (cfg),
    .run_addr_a     (run_addr_a),
    .run_addr_b     (run_addr_b),
    .run_cur        (run_cur),
    .run_next       (run_next),
    .chunk_addr     (chunk_addr),
    .chunk_data     (chunk_data),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res            (res)
  );

  // output register
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_sample_position = out_r.position;
  assign out_sample_number   = out_r.number;
  assign out_status          = out_r.status;

  `CHK_IMPLIES(a_flagged_pos_zero, out_valid && (out_status != ST_OK),
               out_sample_position == '0, "flagged result with nonzero position")

  `CHK_IMPLIES(a_number_in_range, out_valid && (out_status != ST_BEYOND),
               out_sample_number < cfg.samples_in_use, "placed sample past count")

  `CHK_NEXT(a_place_blocks, in_valid && in_ready && (in_operation == OP_PLACE),
            !in_ready, "input taken while a placement is in progress")

endmodule

`default_nettype wire
